// ----- hw/rtl/sc1a_pkg.sv -----
// sc1a_pkg: scancode codes, output widths and the set-1 key tables
// no dependencies; used by the channel interfaces, the decoder and its checker
package sc1a_pkg;

  localparam int unsigned SCAN_W = 8;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned TABLE_LEN = 58;
  localparam int unsigned IDX_W = $clog2(TABLE_LEN);

  // scancodes with a meaning of their own
  localparam logic [SCAN_W-1:0] SC_PREFIX       = 8'hE0;
  localparam logic [SCAN_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [SCAN_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [SCAN_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [SCAN_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [SCAN_W-1:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [SCAN_W-1:0] SC_CTRL_BREAK   = 8'h9D;
  localparam logic [SCAN_W-1:0] SC_UP           = 8'h48;
  localparam logic [SCAN_W-1:0] SC_DOWN         = 8'h50;
  localparam logic [SCAN_W-1:0] SC_RIGHT        = 8'h4D;
  localparam logic [SCAN_W-1:0] SC_LEFT         = 8'h4B;

  // characters of the arrow escape sequence
  localparam logic [CHAR_W-1:0] CH_ESC     = 7'h1B;
  localparam logic [CHAR_W-1:0] CH_BRACKET = 7'h5B;
  localparam logic [CHAR_W-1:0] CH_UP      = 7'h41;
  localparam logic [CHAR_W-1:0] CH_DOWN    = 7'h42;
  localparam logic [CHAR_W-1:0] CH_RIGHT   = 7'h43;
  localparam logic [CHAR_W-1:0] CH_LEFT    = 7'h44;
  localparam logic [CHAR_W-1:0] CH_NONE    = 7'h00;
  localparam logic [CHAR_W-1:0] CTRL_MASK  = 7'h1F;

  // unshifted key table, zero for keys with no character
  function automatic logic [CHAR_W-1:0] plain_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      6'd2:  c = 7'h31;  6'd3:  c = 7'h32;  6'd4:  c = 7'h33;  6'd5:  c = 7'h34;
      6'd6:  c = 7'h35;  6'd7:  c = 7'h36;  6'd8:  c = 7'h37;  6'd9:  c = 7'h38;
      6'd10: c = 7'h39;  6'd11: c = 7'h30;  6'd12: c = 7'h2D;  6'd13: c = 7'h3D;
      6'd14: c = 7'h08;
      6'd16: c = 7'h71;  6'd17: c = 7'h77;  6'd18: c = 7'h65;  6'd19: c = 7'h72;
      6'd20: c = 7'h74;  6'd21: c = 7'h79;  6'd22: c = 7'h75;  6'd23: c = 7'h69;
      6'd24: c = 7'h6F;  6'd25: c = 7'h70;  6'd26: c = 7'h5B;  6'd27: c = 7'h5D;
      6'd28: c = 7'h0A;
      6'd30: c = 7'h61;  6'd31: c = 7'h73;  6'd32: c = 7'h64;  6'd33: c = 7'h66;
      6'd34: c = 7'h67;  6'd35: c = 7'h68;  6'd36: c = 7'h6A;  6'd37: c = 7'h6B;
      6'd38: c = 7'h6C;  6'd39: c = 7'h3B;  6'd40: c = 7'h27;  6'd41: c = 7'h60;
      6'd43: c = 7'h5C;  6'd44: c = 7'h7A;  6'd45: c = 7'h78;  6'd46: c = 7'h63;
      6'd47: c = 7'h76;  6'd48: c = 7'h62;  6'd49: c = 7'h6E;  6'd50: c = 7'h6D;
      6'd51: c = 7'h2C;  6'd52: c = 7'h2E;  6'd53: c = 7'h2F;  6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // shifted key table
  function automatic logic [CHAR_W-1:0] upper_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      6'd2:  c = 7'h21;  6'd3:  c = 7'h40;  6'd4:  c = 7'h23;  6'd5:  c = 7'h24;
      6'd6:  c = 7'h25;  6'd7:  c = 7'h5E;  6'd8:  c = 7'h26;  6'd9:  c = 7'h2A;
      6'd10: c = 7'h28;  6'd11: c = 7'h29;  6'd12: c = 7'h5F;  6'd13: c = 7'h2B;
      6'd14: c = 7'h08;
      6'd16: c = 7'h51;  6'd17: c = 7'h57;  6'd18: c = 7'h45;  6'd19: c = 7'h52;
      6'd20: c = 7'h54;  6'd21: c = 7'h59;  6'd22: c = 7'h55;  6'd23: c = 7'h49;
      6'd24: c = 7'h4F;  6'd25: c = 7'h50;  6'd26: c = 7'h7B;  6'd27: c = 7'h7D;
      6'd28: c = 7'h0A;
      6'd30: c = 7'h41;  6'd31: c = 7'h53;  6'd32: c = 7'h44;  6'd33: c = 7'h46;
      6'd34: c = 7'h47;  6'd35: c = 7'h48;  6'd36: c = 7'h4A;  6'd37: c = 7'h4B;
      6'd38: c = 7'h4C;  6'd39: c = 7'h3A;  6'd40: c = 7'h22;  6'd41: c = 7'h7E;
      6'd43: c = 7'h7C;  6'd44: c = 7'h5A;  6'd45: c = 7'h58;  6'd46: c = 7'h43;
      6'd47: c = 7'h56;  6'd48: c = 7'h42;  6'd49: c = 7'h4E;  6'd50: c = 7'h4D;
      6'd51: c = 7'h3C;  6'd52: c = 7'h3E;  6'd53: c = 7'h3F;  6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/sc1a_scan_if.sv -----
// sc1a_scan_if: valid/ready channel carrying one raw scancode byte per beat
// depends on sc1a_pkg for the byte width
interface sc1a_scan_if;
  logic                          valid;
  logic                          ready;
  logic [sc1a_pkg::SCAN_W-1:0]   scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

// ----- hw/rtl/sc1a_char_if.sv -----
// sc1a_char_if: valid/ready channel carrying one ascii byte and a last flag per beat
// depends on sc1a_pkg for the character width
interface sc1a_char_if;
  logic                          valid;
  logic                          ready;
  logic [sc1a_pkg::CHAR_W-1:0]   char_byte;
  logic                          last;

  modport source (output valid, output char_byte, output last, input ready);
  modport sink   (input valid, input char_byte, input last, output ready);
endinterface

// ----- hw/rtl/scancode_set1_to_ascii_unit.sv -----
// scancode_set1_to_ascii_unit: set-1 scancode to ascii decoder
// depends on sc1a_pkg, sc1a_scan_if and sc1a_char_if
//
// scan carries one raw scancode byte per beat; ascii returns zero to three
// bytes per scancode, with last set on the final byte of each run. Modifier
// and prefix bytes, break codes and keys with no character give no beat.
// An arrow key after the E0 prefix gives ESC, '[' and a letter.
// A scancode is taken into an input register, decoded combinationally from
// it and loaded into the result register once that is free, which then shows
// its first byte. The result register steps through the bytes of a run, one
// per cycle while the receiver is ready: a new scancode giving one byte or
// none can be taken every cycle, an arrow sequence occupies the result
// register for its three bytes. The input register can take one byte while a
// result waits. When the receiver stalls, the shown beat holds, the input
// register fills and scan.ready drops until the result register frees.
// Reset empties both registers and clears the shift, ctrl and prefix flags.
module scancode_set1_to_ascii_unit (
  input  logic         clk,
  input  logic         rst,
  sc1a_scan_if.sink    scan,
  sc1a_char_if.source  ascii
);

  typedef struct packed {
    logic                        shift;
    logic                        ctrl;
    logic                        prefix;
    logic                        emit;
    logic                        arrow;
    logic [sc1a_pkg::CHAR_W-1:0] ch;
  } decode_t;

  logic                        in_valid;
  logic [sc1a_pkg::SCAN_W-1:0] in_byte;
  logic                        shift_held;
  logic                        ctrl_held;
  logic                        prefix_seen;
  logic [1:0]                  remain;
  logic [1:0]                  remain_next;
  logic [sc1a_pkg::CHAR_W-1:0] run_char;
  decode_t                     dec;
  logic                        out_free;
  logic                        load;
  logic [sc1a_pkg::CHAR_W-1:0] looked_up;
  logic                        is_letter;

  always_comb begin
    looked_up = shift_held ? sc1a_pkg::upper_char(in_byte[sc1a_pkg::IDX_W-1:0])
                           : sc1a_pkg::plain_char(in_byte[sc1a_pkg::IDX_W-1:0]);
    is_letter = (looked_up >= 7'h61 && looked_up <= 7'h7A) ||
                (looked_up >= 7'h41 && looked_up <= 7'h5A);
  end

  always_comb begin
    dec.shift  = shift_held;
    dec.ctrl   = ctrl_held;
    dec.prefix = prefix_seen;
    dec.emit   = 1'b0;
    dec.arrow  = 1'b0;
    dec.ch     = sc1a_pkg::CH_NONE;
    priority if (in_byte == sc1a_pkg::SC_PREFIX) begin
      dec.prefix = 1'b1;
    end else if (in_byte == sc1a_pkg::SC_LSHIFT_MAKE ||
                 in_byte == sc1a_pkg::SC_RSHIFT_MAKE) begin
      dec.shift = 1'b1;
    end else if (in_byte == sc1a_pkg::SC_LSHIFT_BREAK ||
                 in_byte == sc1a_pkg::SC_RSHIFT_BREAK) begin
      dec.shift = 1'b0;
    end else if (in_byte == sc1a_pkg::SC_CTRL_MAKE) begin
      dec.ctrl = 1'b1;
    end else if (in_byte == sc1a_pkg::SC_CTRL_BREAK) begin
      dec.ctrl = 1'b0;
    end else if (in_byte[sc1a_pkg::SCAN_W-1]) begin
      dec.prefix = 1'b0;
    end else if (prefix_seen) begin
      dec.prefix = 1'b0;
      dec.arrow  = 1'b1;
      priority if (in_byte == sc1a_pkg::SC_UP) begin
        dec.emit = 1'b1;
        dec.ch   = sc1a_pkg::CH_UP;
      end else if (in_byte == sc1a_pkg::SC_DOWN) begin
        dec.emit = 1'b1;
        dec.ch   = sc1a_pkg::CH_DOWN;
      end else if (in_byte == sc1a_pkg::SC_RIGHT) begin
        dec.emit = 1'b1;
        dec.ch   = sc1a_pkg::CH_RIGHT;
      end else if (in_byte == sc1a_pkg::SC_LEFT) begin
        dec.emit = 1'b1;
        dec.ch   = sc1a_pkg::CH_LEFT;
      end else begin
        dec.emit = 1'b0;
      end
    end else if (in_byte < sc1a_pkg::SCAN_W'(sc1a_pkg::TABLE_LEN)) begin
      dec.emit = (looked_up != sc1a_pkg::CH_NONE);
      // ctrl turns a letter into its control code
      dec.ch   = (ctrl_held && is_letter) ? (looked_up & sc1a_pkg::CTRL_MASK)
                                          : looked_up;
    end else begin
      dec.emit = 1'b0;
    end
  end

  // result register can take a new run when it is empty or its current run ends this cycle
  assign out_free   = (remain == 2'd0) || (remain == 2'd1 && ascii.ready);
  assign load       = in_valid && out_free;
  assign scan.ready = !in_valid || out_free;

  always_comb begin
    if (load) begin
      remain_next = dec.emit ? (dec.arrow ? 2'd3 : 2'd1) : 2'd0;
    end else if (remain != 2'd0 && ascii.ready) begin
      remain_next = remain - 2'd1;
    end else begin
      remain_next = remain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      shift_held  <= 1'b0;
      ctrl_held   <= 1'b0;
      prefix_seen <= 1'b0;
      remain      <= 2'd0;
    end else begin
      if (scan.valid && scan.ready) begin
        in_valid <= 1'b1;
      end else if (load) begin
        in_valid <= 1'b0;
      end
      if (load) begin
        shift_held  <= dec.shift;
        ctrl_held   <= dec.ctrl;
        prefix_seen <= dec.prefix;
      end
      remain <= remain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      in_byte <= scan.scan_byte;
    end
    if (load) begin
      run_char <= dec.ch;
    end
  end

  assign ascii.valid = (remain != 2'd0);
  assign ascii.last  = (remain == 2'd1);

  always_comb begin
    unique case (remain)
      2'd3:    ascii.char_byte = sc1a_pkg::CH_ESC;
      2'd2:    ascii.char_byte = sc1a_pkg::CH_BRACKET;
      default: ascii.char_byte = run_char;
    endcase
  end

endmodule

// ----- hw/rtl/sc1a_checker.sv -----
// sc1a_checker: port-level checks on the scancode decoder, bound to its top level
// depends on sc1a_pkg and on the port names of scancode_set1_to_ascii_unit
module sc1a_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        scan_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sc1a_pkg::CHAR_W-1:0] out_char,
  input logic                        out_last
);

  // a stalled beat holds its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled ascii beat changed");

  // a run continues without a gap once its first byte is taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("ascii run broke off before its last beat");

  // escape is always followed by the bracket, which is not the end of the run
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last && out_char == sc1a_pkg::CH_ESC
    |=> out_char == sc1a_pkg::CH_BRACKET && !out_last)
    else $error("escape not followed by bracket");

  // reset leaves nothing to send and the input open
  assert property (@(posedge clk) rst |=> !out_valid && scan_ready)
    else $error("decoder not empty after reset");

endmodule

bind scancode_set1_to_ascii_unit sc1a_checker u_sc1a_checker (
  .clk        (clk),
  .rst        (rst),
  .scan_ready (scan.ready),
  .out_valid  (ascii.valid),
  .out_ready  (ascii.ready),
  .out_char   (ascii.char_byte),
  .out_last   (ascii.last)
);
